/* sv/lpm_pkg.sv */
// Shared types, constants and fixed-point helpers for the lens point mapper
package lpm_pkg;

	// register file geometry: eight 64-bit registers on 8-byte addresses
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned ADDR_W    = REG_IDX_W + 3;
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned NUM_REGS  = 8;

	// payload widths
	localparam int unsigned IN_W  = 16;
	localparam int unsigned OUT_W = 20;

	// pipeline depth of the datapath
	localparam int unsigned NUM_STAGES = 17;

	// reciprocal divider: 2^48 + F/2 is a 49-bit dividend, one quotient bit per cycle
	localparam int unsigned RECIP_STEPS = 49;
	localparam int unsigned RECIP_CNT_W = $clog2(RECIP_STEPS);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LEFT_FOCAL       = 3'd0,
		REG_LEFT_CENTER      = 3'd1,
		REG_LEFT_RADIAL      = 3'd2,
		REG_LEFT_TANGENTIAL  = 3'd3,
		REG_RIGHT_FOCAL      = 3'd4,
		REG_RIGHT_CENTER     = 3'd5,
		REG_RIGHT_RADIAL     = 3'd6,
		REG_RIGHT_TANGENTIAL = 3'd7
	} reg_idx_t;

	localparam logic [DATA_W-1:0] FOCAL_RESET = 64'h0001_0001_0001_0000;
	localparam logic [31:0]       INV_SAT     = 32'hFFFF_FFFF;
	localparam logic signed [31:0] Q_ONE      = 32'sh1000_0000;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

	// per-camera parameters as seen by the datapath
	typedef struct packed {
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] ifx;
		logic [31:0] ify;
	} cam_cfg_t;

	// round a magnitude to nearest, dropping s fraction bits
	function automatic logic [63:0] rnd_mag(input logic [63:0] m, input int unsigned s);
		return (m + (64'd1 << (s - 1))) >> s;
	endfunction

	// apply sign to a magnitude and clamp to 32-bit signed
	function automatic logic signed [31:0] sat_sm(input logic neg, input logic [63:0] m);
		logic signed [31:0] r;
		if (!neg) begin
			r = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
		end else begin
			r = (m > 64'h8000_0000) ? 32'sh8000_0000 : $signed(-m[31:0]);
		end
		return r;
	endfunction

	// Q4.28 product rounding: ties away from zero, then clamp
	function automatic logic signed [31:0] round_q28(input logic signed [63:0] p);
		logic [63:0] m;
		m = p[63] ? 64'(-p) : 64'(p);
		return sat_sm(p[63], rnd_mag(m, 28));
	endfunction

	// clamp a grown sum back to 32-bit signed
	function automatic logic signed [31:0] sat32w(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// magnitude of a pixel offset, known to fit in 32 bits
	function automatic logic [31:0] abs34_lo(input logic signed [33:0] v);
		logic [33:0] m;
		m = v[33] ? 34'(-v) : 34'(v);
		return m[31:0];
	endfunction

	// round u*f from Q.44 to Q.16 and add the center
	function automatic logic signed [36:0] scale_back(input logic neg, input logic [63:0] prod,
			input logic [31:0] c);
		logic [63:0] m;
		logic signed [36:0] s;
		m = rnd_mag(prod, 28);
		s = $signed({2'b00, m[34:0]});
		if (neg) begin
			s = -s;
		end
		return s + $signed({5'b00000, c});
	endfunction

	// round Q.16 to Q.4 and clip; bit 20 flags a clip
	function automatic logic [OUT_W:0] pix_round(input logic signed [36:0] w);
		logic [36:0] mg;
		logic [36:0] r;
		logic [OUT_W:0] o;
		mg = w[36] ? 37'(-w) : 37'(w);
		r  = (mg + 37'd2048) >> 12;
		if (!w[36]) begin
			if (r > 37'd524287) begin
				o = {1'b1, OUT_MAX};
			end else begin
				o = {1'b0, r[OUT_W-1:0]};
			end
		end else begin
			if (r > 37'd524288) begin
				o = {1'b1, OUT_MIN};
			end else begin
				o = {1'b0, 20'(-r[OUT_W-1:0])};
			end
		end
		return o;
	endfunction

endpackage

/* sv/lpm_recip.sv */
// Bit-serial reciprocal unit: inverse focal length = round(2^48 / F), saturated to 32 bits
module lpm_recip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] den,
	output logic [31:0] inv,
	output logic        busy
);

	logic [31:0] inv_q;
	logic        busy_q;
	logic [lpm_pkg::RECIP_CNT_W-1:0] cnt_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [lpm_pkg::RECIP_STEPS-1:0] num_q;
	logic [32:0] quo_q;

	logic [32:0] trial;
	logic        fits;
	logic [31:0] rem_nx;
	logic [32:0] quo_nx;

	// one restoring division step
	always_comb begin
		trial  = {rem_q, num_q[lpm_pkg::RECIP_STEPS-1]};
		fits   = trial >= {1'b0, den_q};
		rem_nx = fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
		quo_nx = {quo_q[31:0], fits};
	end

	// control: start, count down, store the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			inv_q  <= lpm_pkg::INV_SAT;
		end else if (start) begin
			if (den[31:16] == 16'd0) begin
				// focal below one (or zero) saturates at once
				busy_q <= 1'b0;
				inv_q  <= lpm_pkg::INV_SAT;
			end else begin
				busy_q <= 1'b1;
				cnt_q  <= lpm_pkg::RECIP_CNT_W'(lpm_pkg::RECIP_STEPS - 1);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				inv_q  <= quo_nx[32] ? lpm_pkg::INV_SAT : quo_nx[31:0];
			end
		end
	end

	// datapath: load dividend with the rounding half, then shift
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			num_q <= {1'b1, {(lpm_pkg::RECIP_STEPS-1){1'b0}}}
				+ lpm_pkg::RECIP_STEPS'(den[31:1]);
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign inv  = inv_q;
	assign busy = busy_q;

endmodule

/* sv/lpm_regs.sv */
// Configuration register file with reciprocal focal length units
module lpm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lpm_pkg::ADDR_W-1:0]  paddr,
	input  logic [lpm_pkg::DATA_W-1:0]  pwdata,
	output logic [lpm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output lpm_pkg::cam_cfg_t           cfg_left,
	output lpm_pkg::cam_cfg_t           cfg_right,
	output logic                        busy
);

	logic [lpm_pkg::DATA_W-1:0] reg_q [lpm_pkg::NUM_REGS];
	logic [lpm_pkg::REG_IDX_W-1:0] idx;
	logic wr;
	logic wr_lf, wr_rf;
	logic [31:0] inv_lx, inv_ly, inv_rx, inv_ry;
	logic busy_lx, busy_ly, busy_rx, busy_ry;

	assign idx    = paddr[lpm_pkg::ADDR_W-1 -: lpm_pkg::REG_IDX_W];
	assign wr     = psel && penable && pwrite;
	assign wr_lf  = wr && (idx == lpm_pkg::REG_LEFT_FOCAL);
	assign wr_rf  = wr && (idx == lpm_pkg::REG_RIGHT_FOCAL);
	assign pready = 1'b1;
	assign prdata = reg_q[idx];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lpm_pkg::NUM_REGS; i++) begin
				if (lpm_pkg::REG_IDX_W'(i) == lpm_pkg::REG_LEFT_FOCAL ||
					lpm_pkg::REG_IDX_W'(i) == lpm_pkg::REG_RIGHT_FOCAL) begin
					reg_q[i] <= lpm_pkg::FOCAL_RESET;
				end else begin
					reg_q[i] <= '0;
				end
			end
		end else if (wr) begin
			reg_q[idx] <= pwdata;
		end
	end

	// one divider per focal value so back-to-back focal writes never collide
	lpm_recip u_recip_lx (
		.clk(clk), .arst_n(arst_n), .start(wr_lf), .den(pwdata[63:32]),
		.inv(inv_lx), .busy(busy_lx)
	);
	lpm_recip u_recip_ly (
		.clk(clk), .arst_n(arst_n), .start(wr_lf), .den(pwdata[31:0]),
		.inv(inv_ly), .busy(busy_ly)
	);
	lpm_recip u_recip_rx (
		.clk(clk), .arst_n(arst_n), .start(wr_rf), .den(pwdata[63:32]),
		.inv(inv_rx), .busy(busy_rx)
	);
	lpm_recip u_recip_ry (
		.clk(clk), .arst_n(arst_n), .start(wr_rf), .den(pwdata[31:0]),
		.inv(inv_ry), .busy(busy_ry)
	);

	assign busy = busy_lx || busy_ly || busy_rx || busy_ry;

	// unpack per-camera parameters
	always_comb begin
		cfg_left.fx  = reg_q[lpm_pkg::REG_LEFT_FOCAL][63:32];
		cfg_left.fy  = reg_q[lpm_pkg::REG_LEFT_FOCAL][31:0];
		cfg_left.cx  = reg_q[lpm_pkg::REG_LEFT_CENTER][63:32];
		cfg_left.cy  = reg_q[lpm_pkg::REG_LEFT_CENTER][31:0];
		cfg_left.k1  = reg_q[lpm_pkg::REG_LEFT_RADIAL][63:32];
		cfg_left.k2  = reg_q[lpm_pkg::REG_LEFT_RADIAL][31:0];
		cfg_left.p1  = reg_q[lpm_pkg::REG_LEFT_TANGENTIAL][63:32];
		cfg_left.p2  = reg_q[lpm_pkg::REG_LEFT_TANGENTIAL][31:0];
		cfg_left.ifx = inv_lx;
		cfg_left.ify = inv_ly;

		cfg_right.fx  = reg_q[lpm_pkg::REG_RIGHT_FOCAL][63:32];
		cfg_right.fy  = reg_q[lpm_pkg::REG_RIGHT_FOCAL][31:0];
		cfg_right.cx  = reg_q[lpm_pkg::REG_RIGHT_CENTER][63:32];
		cfg_right.cy  = reg_q[lpm_pkg::REG_RIGHT_CENTER][31:0];
		cfg_right.k1  = reg_q[lpm_pkg::REG_RIGHT_RADIAL][63:32];
		cfg_right.k2  = reg_q[lpm_pkg::REG_RIGHT_RADIAL][31:0];
		cfg_right.p1  = reg_q[lpm_pkg::REG_RIGHT_TANGENTIAL][63:32];
		cfg_right.p2  = reg_q[lpm_pkg::REG_RIGHT_TANGENTIAL][31:0];
		cfg_right.ifx = inv_rx;
		cfg_right.ify = inv_ry;
	end

endmodule

/* sv/lpm_pipe.sv */
// Seventeen-stage distortion datapath with per-stage valid bits and bubble collapse
module lpm_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lpm_pkg::IN_W-1:0]          x_in,
	input  logic [lpm_pkg::IN_W-1:0]          y_in,
	input  logic                              right_camera,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [lpm_pkg::OUT_W-1:0]  x_out,
	output logic signed [lpm_pkg::OUT_W-1:0]  y_out,
	output logic                              saturated,
	input  lpm_pkg::cam_cfg_t                 cfg_left,
	input  lpm_pkg::cam_cfg_t                 cfg_right,
	input  logic                              busy
);

	localparam int unsigned NS = lpm_pkg::NUM_STAGES;
	localparam logic [NS-1:0] ALL = '1;

	// stage k (s1..s17) keeps its valid bit at index k-1
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;

	lpm_pkg::cam_cfg_t c0, c1, c6, c7, c8, c14, c15;

	logic                cam_s1;
	logic signed [33:0]  dx_s1, dy_s1;
	logic                cam_s2, nx_s2, ny_s2;
	logic [63:0]         ax_s2, ay_s2;
	logic                cam_s3;
	logic signed [31:0]  mx_s3, my_s3;
	logic                cam_s4;
	logic signed [31:0]  mx_s4, my_s4;
	logic signed [63:0]  pxx_s4, pyy_s4, pxy_s4;
	logic                cam_s5;
	logic signed [31:0]  mx_s5, my_s5, mx2_s5, my2_s5, mxy_s5;
	logic                cam_s6;
	logic signed [31:0]  mx_s6, my_s6, mx2_s6, my2_s6, mxy_s6, r2_s6;
	logic                cam_s7;
	logic signed [31:0]  mx_s7, my_s7, tx_s7, ty_s7;
	logic signed [63:0]  prr_s7, pk1_s7, pp1m_s7, pp2m_s7;
	logic                cam_s8;
	logic signed [31:0]  mx_s8, my_s8, r4_s8, k1r2_s8, p1m_s8, p2m_s8;
	logic signed [63:0]  pp2t_s8, pp1t_s8;
	logic                cam_s9;
	logic signed [31:0]  mx_s9, my_s9, k1r2_s9, p1m_s9, p2m_s9, p2t_s9, p1t_s9;
	logic signed [63:0]  pk2_s9;
	logic                cam_s10;
	logic signed [31:0]  mx_s10, my_s10, k2r4_s10, k1r2_s10;
	logic signed [31:0]  p1m_s10, p2m_s10, p2t_s10, p1t_s10;
	logic                cam_s11;
	logic signed [31:0]  mx_s11, my_s11, gain_s11, p1m_s11, p2m_s11, p2t_s11, p1t_s11;
	logic                cam_s12;
	logic signed [63:0]  pxg_s12, pyg_s12;
	logic signed [31:0]  p1m_s12, p2m_s12, p2t_s12, p1t_s12;
	logic                cam_s13;
	logic signed [31:0]  xg_s13, yg_s13, p1m_s13, p2m_s13, p2t_s13, p1t_s13;
	logic                cam_s14;
	logic signed [31:0]  xu_s14, yu_s14;
	logic                cam_s15, nx_s15, ny_s15;
	logic [63:0]         ax_s15, ay_s15;
	logic signed [36:0]  wx_s16, wy_s16;
	logic signed [lpm_pkg::OUT_W-1:0] x_s17, y_s17;
	logic                sat_s17;

	logic signed [31:0]  rad;
	logic [lpm_pkg::OUT_W:0] px_r, py_r;

	// stage may move when any stage at or after it is empty, or the output drains
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			adv[k] = !out_stall || !(&(vld_q | ~(ALL << k)));
		end
	end

	assign in_stall = busy || !adv[0];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid && !busy;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// select camera parameters where each stage needs them
	always_comb begin
		c0  = right_camera ? cfg_right : cfg_left;
		c1  = cam_s1  ? cfg_right : cfg_left;
		c6  = cam_s6  ? cfg_right : cfg_left;
		c7  = cam_s7  ? cfg_right : cfg_left;
		c8  = cam_s8  ? cfg_right : cfg_left;
		c14 = cam_s14 ? cfg_right : cfg_left;
		c15 = cam_s15 ? cfg_right : cfg_left;
	end

	// s1: pixel offset from the center in Q.16
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			cam_s1 <= right_camera;
			dx_s1  <= $signed({6'd0, x_in, 12'd0}) - $signed({2'd0, c0.cx});
			dy_s1  <= $signed({6'd0, y_in, 12'd0}) - $signed({2'd0, c0.cy});
		end
	end

	// s2: offset times inverse focal, sign kept apart
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cam_s2 <= cam_s1;
			nx_s2  <= dx_s1[33];
			ny_s2  <= dy_s1[33];
			ax_s2  <= {32'd0, lpm_pkg::abs34_lo(dx_s1)} * {32'd0, c1.ifx};
			ay_s2  <= {32'd0, lpm_pkg::abs34_lo(dy_s1)} * {32'd0, c1.ify};
		end
	end

	// s3: normalized coordinates in Q4.28
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			cam_s3 <= cam_s2;
			mx_s3  <= lpm_pkg::sat_sm(nx_s2, lpm_pkg::rnd_mag(ax_s2, 20));
			my_s3  <= lpm_pkg::sat_sm(ny_s2, lpm_pkg::rnd_mag(ay_s2, 20));
		end
	end

	// s4: squares and cross product
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			cam_s4 <= cam_s3;
			mx_s4  <= mx_s3;
			my_s4  <= my_s3;
			pxx_s4 <= 64'(mx_s3) * 64'(mx_s3);
			pyy_s4 <= 64'(my_s3) * 64'(my_s3);
			pxy_s4 <= 64'(mx_s3) * 64'(my_s3);
		end
	end

	// s5: round the products
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			cam_s5 <= cam_s4;
			mx_s5  <= mx_s4;
			my_s5  <= my_s4;
			mx2_s5 <= lpm_pkg::round_q28(pxx_s4);
			my2_s5 <= lpm_pkg::round_q28(pyy_s4);
			mxy_s5 <= lpm_pkg::round_q28(pxy_s4);
		end
	end

	// s6: squared radius
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			cam_s6 <= cam_s5;
			mx_s6  <= mx_s5;
			my_s6  <= my_s5;
			mx2_s6 <= mx2_s5;
			my2_s6 <= my2_s5;
			mxy_s6 <= mxy_s5;
			r2_s6  <= lpm_pkg::sat32w(40'(mx2_s5) + 40'(my2_s5));
		end
	end

	// s7: r2^2, k1*r2, tangential cross terms, inner tangential sums
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			cam_s7  <= cam_s6;
			mx_s7   <= mx_s6;
			my_s7   <= my_s6;
			prr_s7  <= 64'(r2_s6) * 64'(r2_s6);
			pk1_s7  <= 64'($signed(c6.k1)) * 64'(r2_s6);
			pp1m_s7 <= 64'($signed(c6.p1)) * 64'(mxy_s6);
			pp2m_s7 <= 64'($signed(c6.p2)) * 64'(mxy_s6);
			tx_s7   <= lpm_pkg::sat32w(40'(r2_s6) + 40'(mx2_s6) + 40'(mx2_s6));
			ty_s7   <= lpm_pkg::sat32w(40'(r2_s6) + 40'(my2_s6) + 40'(my2_s6));
		end
	end

	// s8: round, and multiply the inner tangential sums
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			cam_s8  <= cam_s7;
			mx_s8   <= mx_s7;
			my_s8   <= my_s7;
			r4_s8   <= lpm_pkg::round_q28(prr_s7);
			k1r2_s8 <= lpm_pkg::round_q28(pk1_s7);
			p1m_s8  <= lpm_pkg::round_q28(pp1m_s7);
			p2m_s8  <= lpm_pkg::round_q28(pp2m_s7);
			pp2t_s8 <= 64'($signed(c7.p2)) * 64'(tx_s7);
			pp1t_s8 <= 64'($signed(c7.p1)) * 64'(ty_s7);
		end
	end

	// s9: k2*r4 and round tangential products
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			cam_s9  <= cam_s8;
			mx_s9   <= mx_s8;
			my_s9   <= my_s8;
			k1r2_s9 <= k1r2_s8;
			p1m_s9  <= p1m_s8;
			p2m_s9  <= p2m_s8;
			pk2_s9  <= 64'($signed(c8.k2)) * 64'(r4_s8);
			p2t_s9  <= lpm_pkg::round_q28(pp2t_s8);
			p1t_s9  <= lpm_pkg::round_q28(pp1t_s8);
		end
	end

	// s10: round k2*r4
	always_ff @(posedge clk) begin
		if (adv[9]) begin
			cam_s10  <= cam_s9;
			mx_s10   <= mx_s9;
			my_s10   <= my_s9;
			k1r2_s10 <= k1r2_s9;
			k2r4_s10 <= lpm_pkg::round_q28(pk2_s9);
			p1m_s10  <= p1m_s9;
			p2m_s10  <= p2m_s9;
			p2t_s10  <= p2t_s9;
			p1t_s10  <= p1t_s9;
		end
	end

	// s11: radial gain 1 + k1*r2 + k2*r4
	always_comb begin
		rad = lpm_pkg::sat32w(40'(k1r2_s10) + 40'(k2r4_s10));
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			cam_s11  <= cam_s10;
			mx_s11   <= mx_s10;
			my_s11   <= my_s10;
			gain_s11 <= lpm_pkg::sat32w(40'(lpm_pkg::Q_ONE) + 40'(rad));
			p1m_s11  <= p1m_s10;
			p2m_s11  <= p2m_s10;
			p2t_s11  <= p2t_s10;
			p1t_s11  <= p1t_s10;
		end
	end

	// s12: scale coordinates by the gain
	always_ff @(posedge clk) begin
		if (adv[11]) begin
			cam_s12 <= cam_s11;
			pxg_s12 <= 64'(mx_s11) * 64'(gain_s11);
			pyg_s12 <= 64'(my_s11) * 64'(gain_s11);
			p1m_s12 <= p1m_s11;
			p2m_s12 <= p2m_s11;
			p2t_s12 <= p2t_s11;
			p1t_s12 <= p1t_s11;
		end
	end

	// s13: round the gain products
	always_ff @(posedge clk) begin
		if (adv[12]) begin
			cam_s13 <= cam_s12;
			xg_s13  <= lpm_pkg::round_q28(pxg_s12);
			yg_s13  <= lpm_pkg::round_q28(pyg_s12);
			p1m_s13 <= p1m_s12;
			p2m_s13 <= p2m_s12;
			p2t_s13 <= p2t_s12;
			p1t_s13 <= p1t_s12;
		end
	end

	// s14: distorted normalized coordinates
	always_ff @(posedge clk) begin
		if (adv[13]) begin
			cam_s14 <= cam_s13;
			xu_s14  <= lpm_pkg::sat32w(40'(xg_s13) + 40'(p1m_s13) + 40'(p1m_s13)
				+ 40'(p2t_s13));
			yu_s14  <= lpm_pkg::sat32w(40'(yg_s13) + 40'(p2m_s13) + 40'(p2m_s13)
				+ 40'(p1t_s13));
		end
	end

	// s15: multiply back by the focal length
	always_ff @(posedge clk) begin
		if (adv[14]) begin
			cam_s15 <= cam_s14;
			nx_s15  <= xu_s14[31];
			ny_s15  <= yu_s14[31];
			ax_s15  <= {32'd0, lpm_pkg::abs32(xu_s14)} * {32'd0, c14.fx};
			ay_s15  <= {32'd0, lpm_pkg::abs32(yu_s14)} * {32'd0, c14.fy};
		end
	end

	// s16: round to Q.16 and add the center
	always_ff @(posedge clk) begin
		if (adv[15]) begin
			wx_s16 <= lpm_pkg::scale_back(nx_s15, ax_s15, c15.cx);
			wy_s16 <= lpm_pkg::scale_back(ny_s15, ay_s15, c15.cy);
		end
	end

	// s17: round to Q.4, clip and flag
	always_comb begin
		px_r = lpm_pkg::pix_round(wx_s16);
		py_r = lpm_pkg::pix_round(wy_s16);
	end

	always_ff @(posedge clk) begin
		if (adv[16]) begin
			x_s17   <= $signed(px_r[lpm_pkg::OUT_W-1:0]);
			y_s17   <= $signed(py_r[lpm_pkg::OUT_W-1:0]);
			sat_s17 <= px_r[lpm_pkg::OUT_W] || py_r[lpm_pkg::OUT_W];
		end
	end

	assign out_valid = vld_q[NS-1];
	assign x_out     = x_s17;
	assign y_out     = y_s17;
	assign saturated = sat_s17;

endmodule

/* sv/lens_distortion_point_map.sv */
// Top level of the stereo lens distortion point mapper
//
//   channel  direction  handshake                 payload
//   input    in         in_valid / in_stall       x_in, y_in, right_camera
//   output   out        out_valid / out_stall     x_out, y_out, saturated
//   config   in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One point enters per cycle while in_stall is low and passes through the 17-stage
// multiply chain. A focal register write starts the bit-serial reciprocal
// units, which hold in_stall high until done unless the value is below one.
// Reset loads focal 1.0 style defaults and saturated inverse focal lengths and
// empties the pipeline. Empty stages close up while the output is stalled, so
// input transfers continue until every stage holds a point.
module lens_distortion_point_map (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lpm_pkg::IN_W-1:0]          x_in,
	input  logic [lpm_pkg::IN_W-1:0]          y_in,
	input  logic                              right_camera,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [lpm_pkg::OUT_W-1:0]  x_out,
	output logic signed [lpm_pkg::OUT_W-1:0]  y_out,
	output logic                              saturated,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lpm_pkg::ADDR_W-1:0]        paddr,
	input  logic [lpm_pkg::DATA_W-1:0]        pwdata,
	output logic [lpm_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	lpm_pkg::cam_cfg_t cfg_left;
	lpm_pkg::cam_cfg_t cfg_right;
	logic busy;

	// register file and reciprocal units
	lpm_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg_left(cfg_left),
		.cfg_right(cfg_right),
		.busy(busy)
	);

	// distortion datapath
	lpm_pipe u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_in(x_in),
		.y_in(y_in),
		.right_camera(right_camera),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.x_out(x_out),
		.y_out(y_out),
		.saturated(saturated),
		.cfg_left(cfg_left),
		.cfg_right(cfg_right),
		.busy(busy)
	);

endmodule

/* sv/lpm_checker.sv */
// Port-level checks for the lens point mapper, bound to the top level
module lpm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [lpm_pkg::OUT_W-1:0]  x_out,
	input logic signed [lpm_pkg::OUT_W-1:0]  y_out,
	input logic                              saturated,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [lpm_pkg::ADDR_W-1:0]        paddr,
	input logic [lpm_pkg::DATA_W-1:0]        pwdata
);

	// a stalled result stays and holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x_out) && $stable(y_out)
			&& $stable(saturated))
		else $error("stalled result changed");

	// a clip flag comes with a coordinate at a range limit
	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> x_out == lpm_pkg::OUT_MAX || x_out == lpm_pkg::OUT_MIN
			|| y_out == lpm_pkg::OUT_MAX || y_out == lpm_pkg::OUT_MIN)
		else $error("saturated without a clipped coordinate");

	// a focal write of one or more starts the divider and holds off input
	a_focal_stall: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite
			&& (paddr[lpm_pkg::ADDR_W-1 -: lpm_pkg::REG_IDX_W] == lpm_pkg::REG_LEFT_FOCAL
			|| paddr[lpm_pkg::ADDR_W-1 -: lpm_pkg::REG_IDX_W] == lpm_pkg::REG_RIGHT_FOCAL)
			&& (pwdata[63:48] != 16'd0 || pwdata[31:16] != 16'd0)
		|=> in_stall)
		else $error("input not held off during reciprocal update");

endmodule

bind lens_distortion_point_map lpm_checker u_lpm_checker (.*);
